/* design/slm_pkg.sv */
// ----------------------------------------------------------------------------
// Segmentation label merge package
// Shared widths, label codes and the command/status types between the
// sequencer and the pair search unit.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int MAX_FEATURES_DEF = 256;

   localparam int NEW_W   = 9;
   localparam int LABEL_W = 10;
   localparam int INDEX_W = 8;
   localparam int KEY_W   = NEW_W + LABEL_W;

   localparam logic [NEW_W-1:0]   UNASSIGNED_NEW   = '1;
   localparam logic [LABEL_W-1:0] UNASSIGNED_LABEL = '1;

   typedef struct packed {
      logic             start;
      logic             clear;
      logic [KEY_W-1:0] key;
   } srch_cmd_type;

   typedef struct packed {
      logic               done;
      logic [LABEL_W-1:0] merged;
   } srch_sts_type;

   function automatic logic [LABEL_W-1:0] extend_label(input logic [NEW_W-1:0] v);
      return {v[NEW_W-1], v};
   endfunction

endpackage

/* design/slm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/slm_pair_search.sv */
// ----------------------------------------------------------------------------
// Pair search unit
// Holds the table of (new, previous) label pairs of the current segmentation
// and scans it with one key comparator, one entry per cycle.
// ----------------------------------------------------------------------------
module slm_pair_search import slm_pkg::*; #(
   parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  srch_cmd_type cmd,
   output srch_sts_type sts
);

   localparam int AW = $clog2(MAX_FEATURES);
   localparam int CW = $clog2(MAX_FEATURES + 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic             issue_ff, issue_in;
   logic [AW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [KEY_W-1:0] key_ff, key_in;

   logic [KEY_W-1:0] rd_data;
   logic             hit;
   logic             miss;
   logic             table_full;

   slm_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_FEATURES)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (miss && !table_full),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // The read data belongs to cmp_idx_ff whenever issue_ff is set.
   assign hit        = (state_ff == S_SCAN) && issue_ff && (rd_data == key_ff);
   assign miss       = (state_ff == S_SCAN) && !issue_ff && (rd_idx_ff >= count_ff);
   assign table_full = (count_ff >= CW'(MAX_FEATURES));

   always_comb begin
      sts.done = hit || miss;
      if (hit) begin
         sts.merged = LABEL_W'(32'(cmp_idx_ff) + 1);
      end else if (!table_full) begin
         sts.merged = LABEL_W'(32'(count_ff) + 1);
      end else begin
         sts.merged = UNASSIGNED_LABEL;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      issue_in   = issue_ff;
      cmp_idx_in = cmp_idx_ff;
      key_in     = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               key_in    = cmd.key;
               rd_idx_in = '0;
               issue_in  = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit || miss) begin
               issue_in = 1'b0;
               state_in = S_IDLE;
            end else if (rd_idx_ff < count_ff) begin
               cmp_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
               issue_in   = 1'b1;
            end else begin
               issue_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // A clear at the end of a segmentation overrides an append in the same cycle.
      if (cmd.clear) begin
         count_in = '0;
      end else if (miss && !table_full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
      end
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      key_ff     <= key_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(MAX_FEATURES)))
      else $error("pair count exceeds table depth");

   assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> (32'(cmp_idx_ff) < 32'(count_ff)))
      else $error("compare index beyond filled pairs");

   assert property (@(posedge clock) disable iff (reset)
      (hit || miss) |=> (state_ff == S_IDLE))
      else $error("search did not stop after finishing");

endmodule

/* design/segmentation_label_merge.sv */
// ----------------------------------------------------------------------------
// Segmentation label merge
// Merges each new per-feature cluster label with the stored previous
// labelling and gives dense ids to distinct label pairs.
// ----------------------------------------------------------------------------
// One transaction per feature; the result strobe cannot be held off by the
// receiver. In the first segmentation after reset, and for dropped features,
// the result appears in the cycle after start and busy never rises. In later
// segmentations a feature first reads its stored label and then, unless
// either label is unassigned, the pair search unit scans the pair memory
// one entry per cycle. No memory clearing is needed after reset.
module segmentation_label_merge import slm_pkg::*; #(
   parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [NEW_W-1:0]   req_new_label,
   input  logic                      req_last,
   output logic                      rsp_strobe,
   output logic signed [LABEL_W-1:0] rsp_merged_label,
   output logic [INDEX_W-1:0]        rsp_feature_index,
   output logic                      rsp_dropped,
   output logic                      rsp_last_out
);

   localparam int AW = $clog2(MAX_FEATURES);
   localparam int CW = $clog2(MAX_FEATURES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      position_ff, position_in;
   logic [CW-1:0]      stored_count_ff, stored_count_in;
   logic               have_previous_ff, have_previous_in;
   logic [NEW_W-1:0]   new_label_ff, new_label_in;
   logic               last_ff, last_in;

   logic               rsp_strobe_ff;
   logic [LABEL_W-1:0] rsp_merged_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_dropped_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic               emit;
   logic [LABEL_W-1:0] emit_merged;
   logic               emit_dropped;
   logic               emit_last;
   logic [CW-1:0]      position_step;
   logic [LABEL_W-1:0] prev_label;

   srch_cmd_type       srch_cmd;
   srch_sts_type       srch_sts;

   slm_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (MAX_FEATURES)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (emit && !emit_dropped),
      .wr_addr (position_ff[AW-1:0]),
      .wr_data (emit_merged),
      .rd_addr (position_ff[AW-1:0]),
      .rd_data (prev_label)
   );

   slm_pair_search #(
      .MAX_FEATURES (MAX_FEATURES)
   ) u_pair_search (
      .clock (clock),
      .reset (reset),
      .cmd   (srch_cmd),
      .sts   (srch_sts)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign position_step = (position_ff < CW'(MAX_FEATURES)) ? position_ff + 1'b1
                                                            : position_ff;

   always_comb begin
      state_in         = state_ff;
      position_in      = position_ff;
      stored_count_in  = stored_count_ff;
      have_previous_in = have_previous_ff;
      new_label_in     = new_label_ff;
      last_in          = last_ff;

      emit         = 1'b0;
      emit_merged  = UNASSIGNED_LABEL;
      emit_dropped = 1'b0;
      emit_last    = last_ff;

      srch_cmd.start = 1'b0;
      srch_cmd.key   = {new_label_ff, prev_label};

      unique case (state_ff)
         ST_IDLE: begin
            emit_last = req_last;
            if (accept) begin
               if (!have_previous_ff) begin
                  emit = 1'b1;
                  if (position_ff < CW'(MAX_FEATURES)) begin
                     emit_merged = extend_label(req_new_label);
                  end else begin
                     emit_dropped = 1'b1;
                  end
               end else if (position_ff < stored_count_ff) begin
                  new_label_in = req_new_label;
                  last_in      = req_last;
                  state_in     = ST_CHECK;
               end else begin
                  emit         = 1'b1;
                  emit_dropped = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (new_label_ff == UNASSIGNED_NEW || prev_label == UNASSIGNED_LABEL) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               srch_cmd.start = 1'b1;
               state_in       = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (srch_sts.done) begin
               emit        = 1'b1;
               emit_merged = srch_sts.merged;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Bookkeeping happens when a transaction's result is issued.
      if (emit) begin
         position_in = position_step;
         if (emit_last) begin
            position_in      = '0;
            have_previous_in = 1'b1;
            if (!have_previous_ff || position_step < stored_count_ff) begin
               stored_count_in = position_step;
            end
         end
      end

      srch_cmd.clear = emit && emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         position_ff      <= '0;
         stored_count_ff  <= '0;
         have_previous_ff <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         position_ff      <= position_in;
         stored_count_ff  <= stored_count_in;
         have_previous_ff <= have_previous_in;
         rsp_strobe_ff    <= emit;
      end
      new_label_ff <= new_label_in;
      last_ff      <= last_in;
      if (emit) begin
         rsp_merged_ff  <= emit_merged;
         rsp_index_ff   <= (32'(position_ff) > 32'd255) ? '1 : INDEX_W'(position_ff);
         rsp_dropped_ff <= emit_dropped;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_merged_label  = $signed(rsp_merged_ff);
   assign rsp_feature_index = rsp_index_ff;
   assign rsp_dropped       = rsp_dropped_ff;
   assign rsp_last_out      = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (accept && !have_previous_ff) |=> rsp_strobe)
      else $error("first segmentation result not issued in the next cycle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_dropped) |-> (rsp_merged_ff == UNASSIGNED_LABEL))
      else $error("dropped result carries an assigned label");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> have_previous_ff)
      else $error("pair merge started without a previous segmentation");

   assert property (@(posedge clock) disable iff (reset)
      (stored_count_ff <= CW'(MAX_FEATURES)))
      else $error("stored length exceeds the label store");

endmodule

/* tb/sv/segmentation_label_merge_tb.sv */
// ----------------------------------------------------------------------------
// Segmentation label merge testbench
// Streams whole segmentations of feature labels into the block through the
// start/busy command port and checks every result strobe against an
// in-bench prediction of the label store and the per-segmentation pair ids.
// The sender idles at varying rates so that gaps land on every phase of the
// pair search.
// ----------------------------------------------------------------------------
module segmentation_label_merge_tb;
   import slm_pkg::*;

   localparam int FEATURES     = MAX_FEATURES_DEF;
   localparam int FEAT_AW      = $clog2(FEATURES);
   localparam int STALL_LIMIT  = 4096;
   localparam int MAX_REPORTED = 10;

   typedef struct packed {
      logic [NEW_W-1:0] label;
      logic             last;
   } feature_item_type;

   typedef struct packed {
      logic [LABEL_W-1:0] merged;
      logic [INDEX_W-1:0] index;
      logic               dropped;
      logic               last;
   } label_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [NEW_W-1:0]   req_new_label = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_strobe;
   logic signed [LABEL_W-1:0] rsp_merged_label;
   logic [INDEX_W-1:0]        rsp_feature_index;
   logic                      rsp_dropped;
   logic                      rsp_last_out;

   segmentation_label_merge dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_new_label     (req_new_label),
      .req_last          (req_last),
      .rsp_strobe        (rsp_strobe),
      .rsp_merged_label  (rsp_merged_label),
      .rsp_feature_index (rsp_feature_index),
      .rsp_dropped       (rsp_dropped),
      .rsp_last_out      (rsp_last_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted block state.
   logic [LABEL_W-1:0] label_store [FEATURES];
   logic [KEY_W-1:0]   pair_table [FEATURES];
   logic [8:0]         stored_len = '0;
   logic [8:0]         feat_pos = '0;
   bit                 have_prev = 1'b0;
   int                 n_pairs = 0;

   feature_item_type label_feed[$];
   label_result_type expected_merges[$];
   feature_item_type next_item;
   int               n_taken = 0;
   int               mismatches = 0;
   int               stall_cycles = 0;

   // Works out the result of one accepted feature and advances the state.
   task automatic merge_feature(input logic [NEW_W-1:0] nl, input logic lst);
      logic [LABEL_W-1:0] prev_label;
      logic [KEY_W-1:0]   key;
      label_result_type   r;
      int                 j;
      bit                 found;
      r.merged  = UNASSIGNED_LABEL;
      r.dropped = 1'b0;
      r.last    = lst;
      r.index   = (feat_pos > 255) ? 8'hFF : feat_pos[INDEX_W-1:0];
      if (!have_prev) begin
         if (feat_pos < FEATURES) begin
            r.merged = LABEL_W'($signed(nl));
            label_store[feat_pos[FEAT_AW-1:0]] = r.merged;
         end else begin
            r.dropped = 1'b1;
         end
      end else if (feat_pos < stored_len && feat_pos < FEATURES) begin
         prev_label = label_store[feat_pos[FEAT_AW-1:0]];
         if (nl != UNASSIGNED_NEW && prev_label != UNASSIGNED_LABEL) begin
            key   = {nl, prev_label};
            found = 1'b0;
            for (j = 0; j < n_pairs; j++) begin
               if (pair_table[FEAT_AW'(j)] == key) begin
                  found = 1'b1;
                  break;
               end
            end
            if (found) begin
               r.merged = LABEL_W'(j + 1);
            end else if (n_pairs < FEATURES) begin
               pair_table[FEAT_AW'(n_pairs)] = key;
               n_pairs++;
               r.merged = LABEL_W'(n_pairs);
            end
         end
         label_store[feat_pos[FEAT_AW-1:0]] = r.merged;
      end else begin
         r.dropped = 1'b1;
      end
      expected_merges = {expected_merges, r};
      if (feat_pos < FEATURES) feat_pos++;
      if (lst) begin
         if (!have_prev) begin
            stored_len = feat_pos;
            have_prev  = 1'b1;
         end else if (feat_pos < stored_len) begin
            stored_len = feat_pos;
         end
         n_pairs  = 0;
         feat_pos = '0;
      end
   endtask

   // Idle rate of the sender, stepping through the phases as items are taken.
   // The receiver phase has no effect on the sender, since results cannot be
   // held off.
   function automatic int sender_idle_pct();
      case ((n_taken / 97) % 4)
         1: begin
            return 78;
         end
         3: begin
            return 14;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic logic [NEW_W-1:0] pick_label(input int palette);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return UNASSIGNED_NEW;
      if (roll < 13) return NEW_W'($urandom);
      return NEW_W'($urandom_range(0, palette - 1));
   endfunction

   task automatic push_feature(input logic [NEW_W-1:0] label, input logic lst);
      feature_item_type it;
      it.label = label;
      it.last  = lst;
      label_feed = {label_feed, it};
   endtask

   // Queues count random labels; the final one closes the segmentation.
   task automatic push_segment_tail(input int count, input int palette);
      int k;
      for (k = 0; k < count; k++) begin
         push_feature(pick_label(palette), k == count - 1);
      end
   endtask

   // Driver: a transaction completes at an edge where start is high and busy
   // is low; a held start keeps its item until then.
   always @(posedge clock) begin
      if (reset) begin
         start         <= 1'b0;
         req_new_label <= '0;
         req_last      <= 1'b0;
      end else begin
         if (start && !busy) begin
            merge_feature(req_new_label, req_last);
            n_taken++;
         end
         if (!start || !busy) begin
            if (label_feed.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
               next_item = label_feed.pop_front();
               start         <= 1'b1;
               req_new_label <= next_item.label;
               req_last      <= next_item.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobe is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_merges.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
               $display("unexpected result: label %0d index %0d dropped %0b last %0b",
                        rsp_merged_label, rsp_feature_index, rsp_dropped, rsp_last_out);
            end
         end else begin
            automatic label_result_type exp_r = expected_merges.pop_front();
            if (rsp_merged_label !== exp_r.merged || rsp_feature_index !== exp_r.index ||
                rsp_dropped !== exp_r.dropped || rsp_last_out !== exp_r.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTED) begin
                  $display("mismatch: expected label %0d index %0d dropped %0b last %0b",
                           $signed(exp_r.merged), exp_r.index, exp_r.dropped, exp_r.last);
                  $display("          actual   label %0d index %0d dropped %0b last %0b",
                           rsp_merged_label, rsp_feature_index, rsp_dropped, rsp_last_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("segmentation_label_merge regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // First segmentation: extremes of the label field, then enough random
      // features to run past the store so the tail is dropped and the index
      // saturates.
      push_feature(9'h000, 1'b0);
      push_feature(9'h0FF, 1'b0);
      push_feature(UNASSIGNED_NEW, 1'b0);
      push_feature(9'h100, 1'b0);
      push_feature(9'h1FE, 1'b0);
      push_feature(9'h001, 1'b0);
      push_feature(9'h001, 1'b0);
      push_feature(9'h080, 1'b0);
      push_feature(9'h0AA, 1'b0);
      push_feature(9'h155, 1'b0);
      push_segment_tail(FEATURES + 4 - 10, 16);

      // Second segmentation: repeated pairs, an unassigned label on either
      // side, a negative label used as an ordinary one, and a dropped tail.
      push_feature(9'h005, 1'b0);
      push_feature(9'h005, 1'b0);
      push_feature(9'h007, 1'b0);
      push_feature(UNASSIGNED_NEW, 1'b0);
      push_feature(9'h100, 1'b0);
      push_feature(9'h005, 1'b0);
      push_feature(9'h005, 1'b0);
      push_feature(9'h0FF, 1'b0);
      push_feature(9'h000, 1'b0);
      push_feature(9'h1FE, 1'b0);
      push_segment_tail(FEATURES + 2 - 10, 8);

      // Full-length segmentations, one with few distinct pairs and one with
      // many so the pair search runs long.
      push_segment_tail($urandom_range(FEATURES, FEATURES + 3), 4);
      push_segment_tail($urandom_range(FEATURES, FEATURES + 3), 256);

      // Shorter segmentations shrink the stored length step by step, down to
      // a single feature; the last two run past it.
      push_segment_tail(64, 12);
      push_segment_tail(9, 6);
      push_segment_tail(2, 3);
      push_segment_tail(1, 2);
      push_segment_tail(4, 2);
      push_segment_tail(4, 512);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (label_feed.size() != 0 || start || expected_merges.size() != 0) begin
         @(posedge clock);
      end
      repeat (FEATURES + 8) @(posedge clock);
      if (mismatches == 0 && expected_merges.size() == 0) begin
         $display("segmentation_label_merge regression: pass");
      end else begin
         $display("segmentation_label_merge regression: fail");
      end
      $finish;
   end

endmodule
